// File: rtl/sc1t_pkg.sv
// Shared types and constants for the scan code set 1 translator.
// Holds the command format passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package sc1t_pkg;

  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 32;
  localparam int BYTE_W  = 8;
  localparam int MODS_W  = 4;
  localparam int LEVEL_W = 7;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  last_byte;
    logic [MODS_W-1:0]  mods;
  } cmd_t;

endpackage

// File: rtl/scancode_set1_translator_fifo_unit.sv
// Top level of the scan code set 1 translator with character buffer.
// Instantiates sc1t_front, sc1t_cmdq and sc1t_back; depends on sc1t_pkg.
//
// Usage:
//   Input stream: each request is either a keyboard byte (in_tuser[0] = 0) or a
//   host character read (in_tuser[0] = 1). in_tuser[1] marks a byte from the aux
//   port, which is ignored. in_tdata[7:0] holds the scan byte.
//   Output stream: exactly one result per request, in order. out_tuser is high
//   when a read returned a character; out_tdata carries the character, the
//   buffer level after the request, the byte count, the last byte and modifiers.
//   Path: an accepted request is written into the command queue, then executed into the result register.
//   Throughput: one request per cycle while out_tready is high; the front end, the
//   two-entry command queue and the result register then each advance every cycle.
//   Reset: modifiers, prefix, counters and buffer pointers clear; buffer slots
//   are only read after being written.
//   Stall: a held result keeps out_tvalid high; the command queue absorbs two
//   requests, then in_tready drops until the result is taken.
`timescale 1ns / 1ps

module scancode_set1_translator_fifo_unit #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // scan_byte[7:0]
  input  logic [1:0]  in_tuser,   // req_type[0], from_aux[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // char_code[6:0], fifo_level[13:7], byte_count[45:14],
                                  // last_byte[53:46], modifier_flags[57:54]
  output logic        out_tuser   // char_valid[0]
);

  sc1t_pkg::cmd_t push_cmd;
  sc1t_pkg::cmd_t head_cmd;
  logic           q_ready;
  logic           q_push;
  logic           q_pop;
  logic           head_valid;

  sc1t_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sc1t_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sc1t_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[6:0] != 7'd0)
    else $error("popped character is zero");

  a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(head_valid))
    else $error("result appeared without a queued request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// File: rtl/sc1t_front.sv
// Front end: accepts requests, tracks prefix and modifier state, translates make codes.
// Emits one command per request toward the command queue. Depends on sc1t_pkg.
`timescale 1ns / 1ps

module sc1t_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                q_ready,
  output logic                q_push,
  output sc1t_pkg::cmd_t      q_cmd
);

  localparam logic [7:0] PFX_E0     = 8'hE0;
  localparam logic [7:0] PFX_E1     = 8'hE1;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;

  function automatic logic [6:0] base_char(input logic [6:0] k);
    logic [6:0] c;
    case (k)
      7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
      7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
      7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09; 7'h10: c = 7'h71;
      7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72; 7'h14: c = 7'h74;
      7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69; 7'h18: c = 7'h6F;
      7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D; 7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
      7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
      7'h26: c = 7'h6C; 7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60;
      7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63;
      7'h2F: c = 7'h76; 7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D;
      7'h33: c = 7'h2C; 7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] upper_char(input logic [6:0] k);
    logic [6:0] c;
    case (k)
      7'h01: c = 7'h1B; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
      7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
      7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09; 7'h10: c = 7'h51;
      7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52; 7'h14: c = 7'h54;
      7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49; 7'h18: c = 7'h4F;
      7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D; 7'h1C: c = 7'h0A;
      7'h1E: c = 7'h41; 7'h1F: c = 7'h53; 7'h20: c = 7'h44; 7'h21: c = 7'h46;
      7'h22: c = 7'h47; 7'h23: c = 7'h48; 7'h24: c = 7'h4A; 7'h25: c = 7'h4B;
      7'h26: c = 7'h4C; 7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E;
      7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43;
      7'h2F: c = 7'h56; 7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D;
      7'h33: c = 7'h3C; 7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_lower(input logic [6:0] c);
    return (c >= 7'h61) && (c <= 7'h7A);
  endfunction

  function automatic logic is_upper(input logic [6:0] c);
    return (c >= 7'h41) && (c <= 7'h5A);
  endfunction

  function automatic logic [6:0] translate(input logic [6:0] k, input logic shift,
                                           input logic caps, input logic ctrl);
    logic [6:0] b;
    logic [6:0] r;
    b = base_char(k);
    if (is_lower(b) || is_upper(b)) begin
      r = ((caps != shift) && is_lower(b)) ? b - 7'h20 : b;
    end else begin
      r = shift ? upper_char(k) : b;
    end
    if (ctrl) begin
      if (is_lower(r)) r = r - 7'h60;
      else if (is_upper(r)) r = r - 7'h40;
    end
    return r;
  endfunction

  logic        lshift_r, lshift_nxt;
  logic        rshift_r, rshift_nxt;
  logic        ctrl_r, ctrl_nxt;
  logic        alt_r, alt_nxt;
  logic        caps_r, caps_nxt;
  logic        prefix_r, prefix_nxt;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  recent_r, recent_nxt;
  logic        accept;
  logic        rel;
  logic [6:0]  key;
  logic [6:0]  ch;
  logic [1:0]  kind;

  assign in_tready = q_ready;
  assign accept    = in_tvalid & in_tready;
  assign rel       = in_tdata[7];
  assign key       = in_tdata[6:0];

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    prefix_nxt = prefix_r;
    count_nxt  = count_r;
    recent_nxt = recent_r;
    ch         = 7'h00;
    kind       = sc1t_pkg::KIND_NONE;
    if (in_tuser[0]) begin
      kind = sc1t_pkg::KIND_READ;
    end else if (!in_tuser[1]) begin
      count_nxt  = count_r + 32'd1;
      recent_nxt = in_tdata;
      if (in_tdata == PFX_E0 || in_tdata == PFX_E1) begin
        prefix_nxt = 1'b1;
      end else begin
        prefix_nxt = 1'b0;
        if (prefix_r) begin
          if (key == KEY_CTRL) ctrl_nxt = !rel;
          else if (key == KEY_ALT) alt_nxt = !rel;
        end else begin
          case (key)
            KEY_LSHIFT: lshift_nxt = !rel;
            KEY_RSHIFT: rshift_nxt = !rel;
            KEY_CTRL:   ctrl_nxt   = !rel;
            KEY_ALT:    alt_nxt    = !rel;
            KEY_CAPS:   caps_nxt   = rel ? caps_r : !caps_r;
            default:    ;
          endcase
          if (!rel) begin
            ch   = translate(key, lshift_nxt | rshift_nxt, caps_nxt, ctrl_nxt);
            kind = (ch != 7'h00) ? sc1t_pkg::KIND_CHAR : sc1t_pkg::KIND_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      caps_r   <= 1'b0;
      prefix_r <= 1'b0;
      count_r  <= 32'd0;
      recent_r <= 8'd0;
    end else if (accept) begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      ctrl_r   <= ctrl_nxt;
      alt_r    <= alt_nxt;
      caps_r   <= caps_nxt;
      prefix_r <= prefix_nxt;
      count_r  <= count_nxt;
      recent_r <= recent_nxt;
    end
  end

  assign q_push           = accept;
  assign q_cmd.kind       = kind;
  assign q_cmd.ch         = ch;
  assign q_cmd.byte_count = count_nxt;
  assign q_cmd.last_byte  = recent_nxt;
  assign q_cmd.mods       = {caps_nxt, alt_nxt, ctrl_nxt, lshift_nxt | rshift_nxt};

endmodule

// File: rtl/sc1t_cmdq.sv
// Two-entry command queue between the front end and the back end.
// Depends on sc1t_pkg for the command type.
`timescale 1ns / 1ps

module sc1t_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sc1t_pkg::cmd_t push_cmd,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output sc1t_pkg::cmd_t head_cmd
);

  sc1t_pkg::cmd_t slot_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign ready      = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = slot_r[rp_r];
  assign do_push    = push & ready;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/sc1t_back.sv
// Back end: character ring buffer and the registered result stage.
// Executes one command per cycle when the result register is free. Depends on sc1t_pkg.
`timescale 1ns / 1ps

module sc1t_back #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  sc1t_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic           out_tuser
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic [sc1t_pkg::CHAR_W-1:0]  mem [FIFO_DEPTH];
  logic [AW-1:0]                wr_r, wr_nxt, wr_inc;
  logic [AW-1:0]                rd_r, rd_nxt, rd_inc;
  logic [AW:0]                  level;
  logic                         empty, full;
  logic                         exec, do_push, do_pop;
  logic                         valid_r, valid_nxt;
  logic                         popped_r;
  logic [sc1t_pkg::CHAR_W-1:0]  rd_data_r;
  logic [sc1t_pkg::LEVEL_W-1:0] level_r;
  logic [sc1t_pkg::COUNT_W-1:0] count_r;
  logic [sc1t_pkg::BYTE_W-1:0]  last_r;
  logic [sc1t_pkg::MODS_W-1:0]  mods_r;
  logic [sc1t_pkg::CHAR_W-1:0]  code;

  assign wr_inc  = (wr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc  = (rd_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
  assign empty   = (wr_r == rd_r);
  assign full    = (wr_inc == rd_r);
  assign exec    = cmd_valid & (!valid_r | out_tready);
  assign do_push = exec & (cmd.kind == sc1t_pkg::KIND_CHAR) & !full;
  assign do_pop  = exec & (cmd.kind == sc1t_pkg::KIND_READ) & !empty;
  assign cmd_pop = exec;

  always_comb begin
    wr_nxt = do_push ? wr_inc : wr_r;
    rd_nxt = do_pop ? rd_inc : rd_r;
    if (wr_nxt >= rd_nxt) begin
      level = {1'b0, wr_nxt} - {1'b0, rd_nxt};
    end else begin
      level = {1'b0, wr_nxt} + (AW+1)'(FIFO_DEPTH) - {1'b0, rd_nxt};
    end
    if (exec) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= cmd.ch;
    end
    if (do_pop) begin
      rd_data_r <= mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      popped_r <= do_pop;
      level_r  <= sc1t_pkg::LEVEL_W'(level);
      count_r  <= cmd.byte_count;
      last_r   <= cmd.last_byte;
      mods_r   <= cmd.mods;
    end
  end

  assign code       = popped_r ? rd_data_r : '0;
  assign out_tvalid = valid_r;
  assign out_tuser  = popped_r;
  assign out_tdata  = {6'd0, mods_r, last_r, count_r, level_r, code};

endmodule
